// ===== sv/nad_pkg.sv =====
// Package for the normalised attribute distance block.
// Beat layouts, register indexes and fixed-point constants; no dependencies.
package nad_pkg;

   localparam int VAL_W     = 32;
   localparam int KIND_W    = 2;
   localparam int DIST_W    = 40;
   localparam int PROD_W    = 47;   // (31-bit scale * 32-bit magnitude) >> 16
   localparam int REQ_W     = 104;  // 98 field bits, zero filled to whole bytes
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_UNK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_CONT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DISC = 2'd1;

   localparam logic [VAL_W-1:0] HALF_Q16 = 32'h0000_8000;
   localparam logic [VAL_W-1:0] ONE_Q16  = 32'h0001_0000;

   typedef struct packed {
      logic [5:0]       pad;
      logic [VAL_W-1:0] attr_scale;
      logic             b_unknown;
      logic             a_unknown;
      logic [VAL_W-1:0] value_b;
      logic [VAL_W-1:0] value_a;
   } req_data_type;

endpackage

// ===== sv/normalized_attr_distance.sv =====
// Pipeline: a beat with tlast accepted on req passes the input register, then the
// select, multiply and clamp stages, and is then accumulated into the output register
// shown on rsp. Throughput: one attribute beat per cycle; the pipe stalls only while a
// finished result waits in the output register and a later last beat reaches it.
// Reset (synchronous, active high) empties the pipe, clears accumulator and
// saturation flag and sets normalise on, skip-unknowns off, metric to sum.
module normalized_attr_distance #(
   parameter int ACC_BITS = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // value_a[31:0], value_b[63:32], a_unknown[64], b_unknown[65], attr_scale[97:66]
   input  logic [nad_pkg::REQ_W-1:0]    req_tdata,
   // attr_kind[1:0]
   input  logic [nad_pkg::KIND_W-1:0]   req_tuser,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // distance[39:0]
   output logic [nad_pkg::DIST_W-1:0]   rsp_tdata,
   // saturated[0]
   output logic                         rsp_tuser,
   input  logic                         csr_wen,
   input  logic [nad_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                         csr_wdata
);
   import nad_pkg::*;

   // configuration
   logic norm_ff, skip_ff, metric_ff;

   // stage 1: input register
   logic               s1_v_ff, s1_v_in, s1_last_ff;
   req_data_type       s1_data_ff;
   logic [KIND_W-1:0]  s1_kind_ff;

   // stage 2: selected value and scale
   logic               s2_v_ff, s2_v_in, s2_last_ff, s2_prod_ff;
   logic [VAL_W-1:0]   s2_val_ff, s2_val_in;
   logic [VAL_W-2:0]   s2_scale_ff;
   logic               s2_prod_in;

   // stage 3: product
   logic               s3_v_ff, s3_v_in, s3_last_ff;
   logic [PROD_W-1:0]  s3_raw_ff, s3_raw_in;

   // stage 4: clamped difference
   logic               s4_v_ff, s4_v_in, s4_last_ff, s4_sat_ff, s4_sat_in;
   logic [ACC_BITS-1:0] s4_d_ff, s4_d_in;

   // accumulator and output register
   logic [ACC_BITS-1:0] acc_ff, acc_in, acc_new;
   logic                sat_ff, sat_in, sat_new;
   logic                rsp_v_ff, rsp_v_in, rsp_sat_ff, rsp_sat_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic s1_go, s2_go, s3_go, s4_go, s4_take, rsp_load;

   // flow control
   assign s4_go   = !s4_v_ff || !s4_last_ff || !rsp_v_ff || rsp_tready;
   assign s3_go   = !s3_v_ff || s4_go;
   assign s2_go   = !s2_v_ff || s3_go;
   assign s1_go   = !s1_v_ff || s2_go;
   assign s4_take = s4_v_ff && s4_go;
   assign rsp_load = s4_take && s4_last_ff;

   assign req_tready = s1_go;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_dist_ff;
   assign rsp_tuser  = rsp_sat_ff;

   assign s1_v_in = s1_go ? (req_tvalid && req_tready) : s1_v_ff;
   assign s2_v_in = s2_go ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_go ? s2_v_ff : s3_v_ff;
   assign s4_v_in = s4_go ? s3_v_ff : s4_v_ff;
   assign rsp_v_in = rsp_load || (rsp_v_ff && !rsp_tready);

   // stage 2 selection
   logic signed [VAL_W-1:0] va, vb, sc;
   logic [VAL_W:0]          dfull, dabs;
   logic [16:0]             dint, dint_abs;
   logic [VAL_W-1:0]        mag;
   logic                    unk, cont, disc, differ, sc_pos, sc_neg;

   always_comb begin
      va     = s1_data_ff.value_a;
      vb     = s1_data_ff.value_b;
      sc     = s1_data_ff.attr_scale;
      unk    = s1_data_ff.a_unknown || s1_data_ff.b_unknown;
      cont   = s1_kind_ff == KIND_CONT;
      disc   = s1_kind_ff == KIND_DISC;
      sc_neg = sc[VAL_W-1];
      sc_pos = !sc[VAL_W-1] && (sc != '0);
      dfull  = {va[VAL_W-1], va} - {vb[VAL_W-1], vb};
      dabs   = dfull[VAL_W] ? (~dfull + 1'b1) : dfull;
      dint   = {va[VAL_W-1], va[VAL_W-1:16]} - {vb[VAL_W-1], vb[VAL_W-1:16]};
      dint_abs = dint[16] ? (~dint + 1'b1) : dint;
      mag    = disc ? {dint_abs[15:0], 16'h0000} : dabs[VAL_W-1:0];
      differ = disc ? (va[VAL_W-1:16] != vb[VAL_W-1:16]) : (va != vb);
      s2_val_in  = '0;
      s2_prod_in = 1'b0;
      if (unk) begin
         s2_val_in = ((sc != '0) && !skip_ff) ? HALF_Q16 : '0;
      end else if (norm_ff) begin
         if (sc_pos && (cont || disc)) begin
            s2_val_in  = mag;
            s2_prod_in = 1'b1;
         end else if (sc_neg) begin
            s2_val_in = differ ? ONE_Q16 : '0;
         end
      end else begin
         if (cont) begin
            s2_val_in = mag;
         end else if (sc_pos) begin
            s2_val_in = disc ? mag : (differ ? ONE_Q16 : '0);
         end
      end
   end

   // stage 3 multiply
   logic [2*VAL_W-2:0] prod;
   assign prod      = s2_scale_ff * s2_val_ff;
   assign s3_raw_in = s2_prod_ff ? prod[2*VAL_W-2:16] : PROD_W'(s2_val_ff);

   // stage 4 clamp to accumulator range
   generate
      if (ACC_BITS >= PROD_W) begin : g_noclamp
         assign s4_d_in   = ACC_BITS'(s3_raw_ff);
         assign s4_sat_in = 1'b0;
      end else begin : g_clamp
         assign s4_sat_in = |s3_raw_ff[PROD_W-1:ACC_BITS];
         assign s4_d_in   = s4_sat_in ? '1 : s3_raw_ff[ACC_BITS-1:0];
      end
   endgenerate

   // accumulate
   logic [ACC_BITS:0] sum;
   always_comb begin
      sum = {1'b0, acc_ff} + {1'b0, s4_d_ff};
      if (metric_ff) begin
         acc_new = (s4_d_ff > acc_ff) ? s4_d_ff : acc_ff;
      end else begin
         acc_new = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
      end
      sat_new = sat_ff || s4_sat_ff || (!metric_ff && sum[ACC_BITS]);
      acc_in  = acc_ff;
      sat_in  = sat_ff;
      if (s4_take) begin
         acc_in = s4_last_ff ? '0 : acc_new;
         sat_in = s4_last_ff ? 1'b0 : sat_new;
      end
   end

   generate
      if (ACC_BITS > DIST_W) begin : g_outclamp
         logic out_ovf;
         assign out_ovf     = |acc_new[ACC_BITS-1:DIST_W];
         assign rsp_dist_in = out_ovf ? '1 : acc_new[DIST_W-1:0];
         assign rsp_sat_in  = sat_new || out_ovf;
      end else begin : g_outwide
         assign rsp_dist_in = DIST_W'(acc_new);
         assign rsp_sat_in  = sat_new;
      end
   endgenerate

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff   <= 1'b1;
         skip_ff   <= 1'b0;
         metric_ff <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
         acc_ff    <= '0;
         sat_ff    <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_NORMALIZE: norm_ff   <= csr_wdata;
               CSR_SKIP_UNK:  skip_ff   <= csr_wdata;
               CSR_METRIC:    metric_ff <= csr_wdata;
               default: ;
            endcase
         end
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         s4_v_ff  <= s4_v_in;
         rsp_v_ff <= rsp_v_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_data_ff <= req_tdata;
         s1_kind_ff <= req_tuser;
         s1_last_ff <= req_tlast;
      end
      if (s2_go) begin
         s2_val_ff   <= s2_val_in;
         s2_prod_ff  <= s2_prod_in;
         s2_scale_ff <= s1_data_ff.attr_scale[VAL_W-2:0];
         s2_last_ff  <= s1_last_ff;
      end
      if (s3_go) begin
         s3_raw_ff  <= s3_raw_in;
         s3_last_ff <= s2_last_ff;
      end
      if (s4_go) begin
         s4_d_ff    <= s4_d_in;
         s4_sat_ff  <= s4_sat_in;
         s4_last_ff <= s3_last_ff;
      end
      if (rsp_load) begin
         rsp_dist_ff <= rsp_dist_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

endmodule

// ===== sv/nad_checker.sv =====
// Port-level checks for normalized_attr_distance, attached by bind.
// Depends on nad_pkg for beat widths.
module nad_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [nad_pkg::DIST_W-1:0]   rsp_tdata,
   input logic                         rsp_tuser
);
   import nad_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   // input only backs up behind an untaken result
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with free output");

endmodule

bind normalized_attr_distance nad_checker u_nad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
